// ===== hw/rtl/bdu_pkg.sv =====
// Shared types and fixed constants of the block average downsampler.
package bdu_pkg;

   localparam int SAMPLE_W      = 24;
   localparam int COORD_W       = 12;
   localparam int COMP_N        = 3;
   localparam int FAC_W         = 5;
   localparam int FAC_MAX       = 31;
   localparam int CFG_SIZE_W    = 13;
   localparam int CFG_SIZE_MAX  = 8191;
   localparam int ROW_W         = 12;
   localparam int MAX_ROW_COUNT = 4096;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 13;

   localparam logic [1:0]            RST_GRID_DIMENSIONS = 2'd2;
   localparam logic [1:0]            RST_COMPONENT_COUNT = 2'd1;
   localparam logic [FAC_W-1:0]      RST_BLOCK_FACTOR    = 5'd2;
   localparam logic [CFG_SIZE_W-1:0] RST_ROW_LENGTH      = 13'd4096;
   localparam logic [CFG_SIZE_W-1:0] RST_ROW_COUNT       = 13'd4096;

   localparam logic [1:0] DIMS_LINE    = 2'd1;
   localparam logic [1:0] COMPS_VECTOR = 2'd3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GRID_DIMENSIONS = 3'd0,
      CSR_COMPONENT_COUNT = 3'd1,
      CSR_BLOCK_FACTOR    = 3'd2,
      CSR_ROW_LENGTH      = 3'd3,
      CSR_ROW_COUNT       = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_DIVIDE,
      ST_EMIT,
      ST_WRAP,
      ST_RECALC
   } state_type;

endpackage

// ===== hw/rtl/bdu_req_if.sv =====
// Input channel interface carrying one grid sample per transaction.
interface bdu_req_if
   import bdu_pkg::*;
();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample_a;
   logic signed [SAMPLE_W-1:0] sample_b;
   logic signed [SAMPLE_W-1:0] sample_c;

   modport source (output valid, output sample_a, output sample_b, output sample_c,
                   input ready);
   modport sink (input valid, input sample_a, input sample_b, input sample_c,
                 output ready);
endinterface

// ===== hw/rtl/bdu_rsp_if.sv =====
// Result channel interface carrying one block average per transaction.
interface bdu_rsp_if
   import bdu_pkg::*;
();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] average_a;
   logic signed [SAMPLE_W-1:0] average_b;
   logic signed [SAMPLE_W-1:0] average_c;
   logic [COORD_W-1:0]         out_column;
   logic [COORD_W-1:0]         out_row;
   logic                       frame_done;

   modport source (output valid, output average_a, output average_b, output average_c,
                   output out_column, output out_row, output frame_done, input ready);
   modport sink (input valid, input average_a, input average_b, input average_c,
                 input out_column, input out_row, input frame_done, output ready);
endinterface

// ===== hw/rtl/bdu_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module bdu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/bdu_divider.sv =====
// Iterative restoring unsigned divider producing one quotient bit per cycle.
module bdu_divider #(
   parameter int NUM_W = 32,
   parameter int DEN_W = 10
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numerator,
   input  logic [DEN_W-1:0] denominator,
   output logic             busy,
   output logic [NUM_W-1:0] quotient,
   output logic [DEN_W-1:0] remainder
);

   localparam int STEP_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0]  quo_ff;
   logic [NUM_W-1:0]  quo_in;
   logic [DEN_W-1:0]  rem_ff;
   logic [DEN_W-1:0]  rem_in;
   logic [DEN_W-1:0]  den_ff;
   logic [DEN_W-1:0]  den_in;
   logic [STEP_W-1:0] count_ff;
   logic [STEP_W-1:0] count_in;
   logic              busy_ff;
   logic              busy_in;
   logic [DEN_W:0]    trial;
   logic [DEN_W:0]    diff;
   logic              take;

   assign trial = {rem_ff, quo_ff[NUM_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign take  = (trial >= {1'b0, den_ff});

   always_comb begin
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      priority if (start) begin
         quo_in   = numerator;
         rem_in   = '0;
         den_in   = denominator;
         count_in = STEP_W'(NUM_W);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         quo_in   = {quo_ff[NUM_W-2:0], take};
         rem_in   = take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         count_in = count_ff - STEP_W'(1);
         busy_in  = (count_ff != STEP_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign busy      = busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== hw/rtl/block_average_downsampler_unit.sv =====
// Top level of the block average downsampler: control, row store and result register.
//
// Samples arrive in raster order and are summed per block column in a row store
// memory, read in the cycle a transaction is accepted and written back in the next,
// with the written sums forwarded when the following sample hits the same column.
// A sample that does not complete a block therefore does not hold up the input, and
// a new sample is accepted in every cycle unless a block completes or a configuration
// write is being handled. A sample that completes a block starts three bit-serial
// dividers, one per component, whose width is 24 plus twice log2 of MAX_FACTOR bits
// (32 bits at the default); input is held until the result has been moved into the
// output register. The result register lets the next sample in while a result still
// waits. After each configuration write the block wraps its raster position to the
// new sizes and recomputes the block coordinates with two further serial dividers,
// accepting no sample until both are done. Averages truncate toward zero.
module block_average_downsampler_unit
   import bdu_pkg::*;
#(
   parameter int MAX_ROW_LENGTH = 4096,
   parameter int MAX_FACTOR     = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   bdu_req_if.sink               req_if,
   bdu_rsp_if.source             rsp_if
);

   localparam int COL_W   = $clog2(MAX_ROW_LENGTH);
   localparam int LEN_W   = $clog2(MAX_ROW_LENGTH + 1);
   localparam int SUM_W   = SAMPLE_W + 2 * $clog2(MAX_FACTOR);
   localparam int CNT_W   = 2 * FAC_W;
   localparam int CMP_W   = (LEN_W > FAC_W) ? LEN_W : FAC_W;
   localparam int LEN_CAP = (MAX_ROW_LENGTH > CFG_SIZE_MAX) ? CFG_SIZE_MAX : MAX_ROW_LENGTH;
   localparam int FAC_CAP = (MAX_FACTOR > FAC_MAX) ? FAC_MAX : MAX_FACTOR;

   state_type state_ff;
   state_type state_in;

   logic [1:0]            cfg_dims_ff;
   logic [1:0]            cfg_dims_in;
   logic [1:0]            cfg_comps_ff;
   logic [1:0]            cfg_comps_in;
   logic [FAC_W-1:0]      cfg_factor_ff;
   logic [FAC_W-1:0]      cfg_factor_in;
   logic [CFG_SIZE_W-1:0] cfg_len_ff;
   logic [CFG_SIZE_W-1:0] cfg_len_in;
   logic [CFG_SIZE_W-1:0] cfg_rows_ff;
   logic [CFG_SIZE_W-1:0] cfg_rows_in;

   logic                  one_d;
   logic                  vec;
   logic [FAC_W-1:0]      fac;
   logic [CFG_SIZE_W-1:0] len_cfg;
   logic [LEN_W-1:0]      len;
   logic [CFG_SIZE_W-1:0] rows;
   logic [CNT_W-1:0]      cnt;

   logic [COL_W-1:0] col_ff;
   logic [COL_W-1:0] col_in;
   logic [COL_W-1:0] bcol_ff;
   logic [COL_W-1:0] bcol_in;
   logic [FAC_W-1:0] icol_ff;
   logic [FAC_W-1:0] icol_in;
   logic [ROW_W-1:0] row_ff;
   logic [ROW_W-1:0] row_in;
   logic [ROW_W-1:0] brow_ff;
   logic [ROW_W-1:0] brow_in;
   logic [FAC_W-1:0] jrow_ff;
   logic [FAC_W-1:0] jrow_in;

   logic [LEN_W-1:0]      col_inc;
   logic [CFG_SIZE_W-1:0] row_inc;
   logic                  last_i;
   logic                  last_j;
   logic                  row_end;
   logic                  frame_wrap;
   logic                  first_smp;
   logic                  complete_smp;
   logic                  done_smp;
   logic [COL_W-1:0]      wrap_col;
   logic [ROW_W-1:0]      wrap_row;

   logic accept;
   logic load_out;
   logic sum_start;
   logic pos_start;
   logic pos_load;
   logic mem_we;

   logic [COL_W-1:0] col_quo;
   logic [FAC_W-1:0] col_rem;
   logic [ROW_W-1:0] row_quo;
   logic [FAC_W-1:0] row_rem;
   logic             col_busy;
   logic             row_busy;
   logic             pos_busy;

   logic [COL_W-1:0] upd_bcol_ff;
   logic [ROW_W-1:0] upd_brow_ff;
   logic             upd_first_ff;
   logic             upd_complete_ff;
   logic             upd_done_ff;
   logic             upd_vec_ff;
   logic             upd_fwd_ff;
   logic [SUM_W-1:0] upd_sample_ff [COMP_N];
   logic [SUM_W-1:0] fwd_sum_ff [COMP_N];
   logic [SUM_W-1:0] in_sample [COMP_N];

   logic [COMP_N*SUM_W-1:0] mem_rd_data;
   logic [COMP_N*SUM_W-1:0] mem_wr_data;
   logic [SUM_W-1:0]        base_sum [COMP_N];
   logic [SUM_W-1:0]        sum_new [COMP_N];
   logic [SUM_W-1:0]        sum_mag [COMP_N];
   logic [SUM_W-1:0]        quo [COMP_N];
   logic [SUM_W-1:0]        quo_fix [COMP_N];
   logic [COMP_N-1:0]       sum_busy;
   logic [COMP_N-1:0]       neg_ff;

   logic [COL_W-1:0] res_bcol_ff;
   logic [ROW_W-1:0] res_brow_ff;
   logic             res_done_ff;
   logic             res_vec_ff;

   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [SAMPLE_W-1:0] avg_ff [COMP_N];
   logic [COORD_W-1:0]  out_col_ff;
   logic [COORD_W-1:0]  out_row_ff;
   logic                out_done_ff;

   // Effective configuration after the out-of-range values have been mapped.
   assign one_d = (cfg_dims_ff == DIMS_LINE);
   assign vec   = (cfg_comps_ff == COMPS_VECTOR) && !one_d;
   assign fac   = (cfg_factor_ff == '0) ? FAC_W'(1) :
                  (cfg_factor_ff > FAC_W'(FAC_CAP)) ? FAC_W'(FAC_CAP) : cfg_factor_ff;
   assign len_cfg = (cfg_len_ff == '0) ? CFG_SIZE_W'(1) :
                    (cfg_len_ff > CFG_SIZE_W'(LEN_CAP)) ? CFG_SIZE_W'(LEN_CAP) : cfg_len_ff;
   assign len  = LEN_W'(len_cfg);
   assign rows = one_d ? CFG_SIZE_W'(1) :
                 (cfg_rows_ff == '0) ? CFG_SIZE_W'(1) :
                 (cfg_rows_ff > CFG_SIZE_W'(MAX_ROW_COUNT)) ? CFG_SIZE_W'(MAX_ROW_COUNT) :
                 cfg_rows_ff;
   assign cnt  = one_d ? CNT_W'(fac) : CNT_W'(fac) * CNT_W'(fac);

   always_comb begin
      cfg_dims_in   = cfg_dims_ff;
      cfg_comps_in  = cfg_comps_ff;
      cfg_factor_in = cfg_factor_ff;
      cfg_len_in    = cfg_len_ff;
      cfg_rows_in   = cfg_rows_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_GRID_DIMENSIONS: cfg_dims_in   = csr_wdata[1:0];
            CSR_COMPONENT_COUNT: cfg_comps_in  = csr_wdata[1:0];
            CSR_BLOCK_FACTOR:    cfg_factor_in = csr_wdata[FAC_W-1:0];
            CSR_ROW_LENGTH:      cfg_len_in    = csr_wdata[CFG_SIZE_W-1:0];
            CSR_ROW_COUNT:       cfg_rows_in   = csr_wdata[CFG_SIZE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Raster position bookkeeping for the sample about to be accepted.
   assign col_inc    = LEN_W'(col_ff) + LEN_W'(1);
   assign row_inc    = CFG_SIZE_W'(row_ff) + CFG_SIZE_W'(1);
   assign last_i     = (icol_ff == fac - FAC_W'(1));
   assign last_j     = (jrow_ff == fac - FAC_W'(1));
   assign row_end    = (col_inc >= len);
   assign frame_wrap = one_d || (row_inc >= rows);

   assign first_smp    = (icol_ff == '0) && (one_d || (jrow_ff == '0));
   assign complete_smp = last_i && (one_d || last_j);
   assign done_smp     = (CMP_W'(len - col_inc) < CMP_W'(fac)) &&
                         (one_d || ((rows - row_inc) < CFG_SIZE_W'(fac)));

   assign wrap_col = (LEN_W'(col_ff) >= len) ? '0 : col_ff;
   assign wrap_row = (one_d || (CFG_SIZE_W'(row_ff) >= rows)) ? '0 : row_ff;

   always_comb begin
      col_in  = col_ff;
      bcol_in = bcol_ff;
      icol_in = icol_ff;
      row_in  = row_ff;
      brow_in = brow_ff;
      jrow_in = jrow_ff;
      priority if (pos_load) begin
         bcol_in = col_quo;
         icol_in = col_rem;
         brow_in = row_quo;
         jrow_in = row_rem;
      end else if (state_ff == ST_WRAP) begin
         col_in = wrap_col;
         row_in = wrap_row;
      end else if (accept) begin
         if (row_end) begin
            col_in  = '0;
            bcol_in = '0;
            icol_in = '0;
            if (frame_wrap) begin
               row_in  = '0;
               brow_in = '0;
               jrow_in = '0;
            end else begin
               row_in  = row_inc[ROW_W-1:0];
               brow_in = last_j ? brow_ff + ROW_W'(1) : brow_ff;
               jrow_in = last_j ? '0 : jrow_ff + FAC_W'(1);
            end
         end else begin
            col_in  = col_inc[COL_W-1:0];
            bcol_in = last_i ? bcol_ff + COL_W'(1) : bcol_ff;
            icol_in = last_i ? '0 : icol_ff + FAC_W'(1);
         end
      end
   end

   // Next state.
   assign pos_busy = col_busy || row_busy;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (upd_complete_ff) begin
               state_in = ST_DIVIDE;
            end else if (accept) begin
               state_in = ST_UPDATE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIVIDE: begin
            if (sum_busy == '0) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               state_in = ST_IDLE;
            end
         end
         ST_WRAP: begin
            state_in = ST_RECALC;
         end
         ST_RECALC: begin
            if (!pos_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (csr_we) begin
         state_in = ST_WRAP;
      end
   end

   // Control outputs.
   always_comb begin
      req_if.ready = 1'b0;
      load_out     = 1'b0;
      sum_start    = 1'b0;
      pos_start    = 1'b0;
      pos_load     = 1'b0;
      mem_we       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_if.ready = 1'b1;
         end
         ST_UPDATE: begin
            req_if.ready = !upd_complete_ff;
            mem_we       = 1'b1;
            sum_start    = upd_complete_ff;
         end
         ST_DIVIDE: begin
         end
         ST_EMIT: begin
            load_out = !rsp_valid_ff || rsp_if.ready;
         end
         ST_WRAP: begin
            pos_start = 1'b1;
         end
         ST_RECALC: begin
            pos_load = !pos_busy;
         end
         default: begin
         end
      endcase
   end

   assign accept = req_if.valid && req_if.ready;

   bdu_divider #(.NUM_W(COL_W), .DEN_W(FAC_W)) u_col_div (
      .clock       (clock),
      .reset       (reset),
      .start       (pos_start),
      .numerator   (wrap_col),
      .denominator (fac),
      .busy        (col_busy),
      .quotient    (col_quo),
      .remainder   (col_rem)
   );

   bdu_divider #(.NUM_W(ROW_W), .DEN_W(FAC_W)) u_row_div (
      .clock       (clock),
      .reset       (reset),
      .start       (pos_start),
      .numerator   (wrap_row),
      .denominator (fac),
      .busy        (row_busy),
      .quotient    (row_quo),
      .remainder   (row_rem)
   );

   // Row store of running block sums, one word of three components per block column.
   assign in_sample[0] = {{(SUM_W-SAMPLE_W){req_if.sample_a[SAMPLE_W-1]}}, req_if.sample_a};
   assign in_sample[1] = vec ?
      {{(SUM_W-SAMPLE_W){req_if.sample_b[SAMPLE_W-1]}}, req_if.sample_b} : '0;
   assign in_sample[2] = vec ?
      {{(SUM_W-SAMPLE_W){req_if.sample_c[SAMPLE_W-1]}}, req_if.sample_c} : '0;

   for (genvar k = 0; k < COMP_N; k++) begin : g_comp
      assign base_sum[k] = upd_fwd_ff ? fwd_sum_ff[k] : mem_rd_data[k*SUM_W +: SUM_W];
      assign sum_new[k]  = upd_first_ff ? upd_sample_ff[k] : base_sum[k] + upd_sample_ff[k];
      assign sum_mag[k]  = sum_new[k][SUM_W-1] ? (~sum_new[k] + SUM_W'(1)) : sum_new[k];
      assign mem_wr_data[k*SUM_W +: SUM_W] = sum_new[k];
      assign quo_fix[k]  = neg_ff[k] ? (~quo[k] + SUM_W'(1)) : quo[k];

      bdu_divider #(.NUM_W(SUM_W), .DEN_W(CNT_W)) u_sum_div (
         .clock       (clock),
         .reset       (reset),
         .start       (sum_start),
         .numerator   (sum_mag[k]),
         .denominator (cnt),
         .busy        (sum_busy[k]),
         .quotient    (quo[k]),
         .remainder   ()
      );
   end

   bdu_ram #(.WIDTH(COMP_N * SUM_W), .DEPTH(MAX_ROW_LENGTH)) u_row_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (upd_bcol_ff),
      .wr_data (mem_wr_data),
      .rd_en   (accept),
      .rd_addr (bcol_ff),
      .rd_data (mem_rd_data)
   );

   assign rsp_valid_in = load_out ? 1'b1 : (rsp_if.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cfg_dims_ff   <= RST_GRID_DIMENSIONS;
         cfg_comps_ff  <= RST_COMPONENT_COUNT;
         cfg_factor_ff <= RST_BLOCK_FACTOR;
         cfg_len_ff    <= RST_ROW_LENGTH;
         cfg_rows_ff   <= RST_ROW_COUNT;
         col_ff        <= '0;
         bcol_ff       <= '0;
         icol_ff       <= '0;
         row_ff        <= '0;
         brow_ff       <= '0;
         jrow_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cfg_dims_ff   <= cfg_dims_in;
         cfg_comps_ff  <= cfg_comps_in;
         cfg_factor_ff <= cfg_factor_in;
         cfg_len_ff    <= cfg_len_in;
         cfg_rows_ff   <= cfg_rows_in;
         col_ff        <= col_in;
         bcol_ff       <= bcol_in;
         icol_ff       <= icol_in;
         row_ff        <= row_in;
         brow_ff       <= brow_in;
         jrow_ff       <= jrow_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         upd_bcol_ff     <= bcol_ff;
         upd_brow_ff     <= brow_ff;
         upd_first_ff    <= first_smp;
         upd_complete_ff <= complete_smp;
         upd_done_ff     <= done_smp;
         upd_vec_ff      <= vec;
         upd_fwd_ff      <= (state_ff == ST_UPDATE) && (bcol_ff == upd_bcol_ff);
         upd_sample_ff   <= in_sample;
      end
      if (mem_we) begin
         fwd_sum_ff <= sum_new;
      end
      if (sum_start) begin
         for (int k = 0; k < COMP_N; k++) begin
            neg_ff[k] <= sum_new[k][SUM_W-1];
         end
         res_bcol_ff <= upd_bcol_ff;
         res_brow_ff <= upd_brow_ff;
         res_done_ff <= upd_done_ff;
         res_vec_ff  <= upd_vec_ff;
      end
      if (load_out) begin
         avg_ff[0]   <= quo_fix[0][SAMPLE_W-1:0];
         avg_ff[1]   <= res_vec_ff ? quo_fix[1][SAMPLE_W-1:0] : '0;
         avg_ff[2]   <= res_vec_ff ? quo_fix[2][SAMPLE_W-1:0] : '0;
         out_col_ff  <= COORD_W'(res_bcol_ff);
         out_row_ff  <= COORD_W'(res_brow_ff);
         out_done_ff <= res_done_ff;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.average_a  = avg_ff[0];
   assign rsp_if.average_b  = avg_ff[1];
   assign rsp_if.average_c  = avg_ff[2];
   assign rsp_if.out_column = out_col_ff;
   assign rsp_if.out_row    = out_row_ff;
   assign rsp_if.frame_done = out_done_ff;

endmodule
